[src/credential_table_engine_macros.svh]
// Assertion macros for the credential table engine.
`ifndef CREDENTIAL_TABLE_ENGINE_MACROS_SVH
`define CREDENTIAL_TABLE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

`define CTE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define CTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CTE_ASSERT_SAME(lbl, ante, cons, msg)

`define CTE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[src/cte_pkg.sv]
package cte_pkg;

	localparam int unsigned NAME_LOW_W  = 64;
	localparam int unsigned NAME_HIGH_W = 48;
	localparam int unsigned NAME_W      = NAME_LOW_W + NAME_HIGH_W;
	localparam int unsigned NAME_BYTES  = NAME_W / 8;
	localparam int unsigned PASS_W      = 16;
	localparam int unsigned CMD_W       = 2;
	localparam int unsigned STATUS_W    = 3;
	localparam int unsigned USER_IDX_W  = 6;
	localparam int unsigned ENTRY_W     = NAME_W + PASS_W;

	localparam int unsigned DEF_SLOT_COUNT = 8;

	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND       = 3'd0,
		ST_WRONG_PASS  = 3'd1,
		ST_NOT_FOUND   = 3'd2,
		ST_ADDED       = 3'd3,
		ST_NO_SPACE    = 3'd4,
		ST_DELETED     = 3'd5,
		ST_NOT_DELETED = 3'd6
	} status_t;

	// zero every byte after the first zero byte
	function automatic logic [NAME_W-1:0] canon_name(
		input logic [NAME_LOW_W-1:0]  lo,
		input logic [NAME_HIGH_W-1:0] hi
	);
		logic [NAME_W-1:0] raw;
		logic [NAME_W-1:0] res;
		logic              alive;
		raw   = {hi, lo};
		res   = '0;
		alive = 1'b1;
		for (int b = 0; b < NAME_BYTES; b++) begin
			if (alive) begin
				res[b*8 +: 8] = raw[b*8 +: 8];
			end
			if (raw[b*8 +: 8] == 8'd0) begin
				alive = 1'b0;
			end
		end
		return res;
	endfunction

endpackage

[src/credential_table_engine.sv]
// Credential table engine: a table of SLOT_COUNT user slots (name key and
// password), searched, filled and freed by request words.
// Input channel (in_valid/in_ready): command, name_low, name_high, password.
// The name must be zero padded; bytes after the first zero byte are ignored.
// Output channel (out_valid/out_ready): status and user_index, one word for
// every request word, in order.
// A request is taken only while the engine is idle. It then scans the slot
// store one slot per cycle through a single read port and one key compare,
// stopping at the first valid match. After the scan the result is
// registered (WB) and then loaded into the output register; an unused
// command skips the scan. Adds and deletes update the table as it ends.
// A new request is taken only after the last result has been loaded.
// The result sits in an output register; the next request may be accepted
// while it waits. If the receiver stalls and a second result is ready, the
// engine holds that result and accepts nothing until the register frees up.
// Reset frees every slot at once through the valid flags; no clearing pass.
`include "credential_table_engine_macros.svh"

module credential_table_engine #(
	parameter int unsigned SLOT_COUNT = cte_pkg::DEF_SLOT_COUNT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [cte_pkg::CMD_W-1:0]          command,
	input  logic [cte_pkg::NAME_LOW_W-1:0]     name_low,
	input  logic [cte_pkg::NAME_HIGH_W-1:0]    name_high,
	input  logic [cte_pkg::PASS_W-1:0]         password,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [cte_pkg::STATUS_W-1:0]       status,
	output logic [cte_pkg::USER_IDX_W-1:0]     user_index
);

	import cte_pkg::*;

	localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
	localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(SLOT_COUNT);

	typedef enum logic [1:0] {IDLE, SCAN, WB} state_t;

	state_t              state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [NAME_W-1:0]   name_q;
	logic [PASS_W-1:0]   pass_q;
	logic [CNT_W-1:0]    scan_q;
	logic [IDX_W-1:0]    cmp_idx_q;
	logic                cmp_pend_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [SLOT_COUNT-1:0] valid_q;
	status_t             res_status_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [IDX_W-1:0]    out_idx_q;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [ENTRY_W-1:0]  ram_rdata;

	logic                issue;
	logic                hit;
	logic                pass_ok;
	logic                slot_free;
	logic                last_cmp;
	logic                scan_done;
	logic                clr_valid;
	logic [IDX_W-1:0]    free_now;
	logic                free_avail;
	status_t             done_status;
	logic [IDX_W-1:0]    done_idx;
	logic                out_load;

	cte_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT),
		.AW    (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign in_ready   = (state_q == IDLE);
	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign user_index = USER_IDX_W'(out_idx_q);
	assign out_load   = (state_q == WB) && (!out_valid_q || out_ready);

	always_comb begin
		issue      = (state_q == SCAN) && (scan_q != END_CNT);
		slot_free  = !valid_q[cmp_idx_q];
		hit        = cmp_pend_q && !slot_free && (ram_rdata[NAME_W-1:0] == name_q);
		pass_ok    = (ram_rdata[ENTRY_W-1:NAME_W] == pass_q);
		last_cmp   = cmp_pend_q && (cmp_idx_q == LAST_IDX);
		scan_done  = (state_q == SCAN) && (hit || last_cmp);
		free_avail = free_found_q || (cmp_pend_q && slot_free);
		free_now   = free_found_q ? free_idx_q : cmp_idx_q;
		ram_we     = 1'b0;
		ram_waddr  = free_now;
		ram_wdata  = {pass_q, name_q};
		clr_valid  = 1'b0;
		done_status = ST_NOT_FOUND;
		done_idx    = '0;
		unique case (cmd_q)
			CMD_SEARCH: begin
				if (hit) begin
					done_status = pass_ok ? ST_FOUND : ST_WRONG_PASS;
					done_idx    = pass_ok ? cmp_idx_q : '0;
				end
			end
			CMD_ADD: begin
				done_status = ST_NO_SPACE;
				if (!hit && free_avail) begin
					done_status = ST_ADDED;
					done_idx    = free_now;
					ram_we      = scan_done;
				end
			end
			CMD_DELETE: begin
				done_status = ST_NOT_DELETED;
				if (hit && pass_ok) begin
					done_status = ST_DELETED;
					done_idx    = cmp_idx_q;
					clr_valid   = scan_done;
				end
			end
			default: begin
				done_status = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			cmp_pend_q   <= 1'b0;
			free_found_q <= 1'b0;
			valid_q      <= '0;
			out_valid_q  <= 1'b0;
			scan_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						cmd_q        <= command;
						name_q       <= canon_name(name_low, name_high);
						pass_q       <= password;
						scan_q       <= '0;
						cmp_pend_q   <= 1'b0;
						free_found_q <= 1'b0;
						if (command == CMD_SEARCH || command == CMD_ADD ||
						    command == CMD_DELETE) begin
							state_q <= SCAN;
						end else begin
							res_status_q <= ST_NOT_FOUND;
							res_idx_q    <= '0;
							state_q      <= WB;
						end
					end
				end
				SCAN: begin
					if (scan_done) begin
						res_status_q <= done_status;
						res_idx_q    <= done_idx;
						cmp_pend_q   <= 1'b0;
						state_q      <= WB;
						if (ram_we) begin
							valid_q[ram_waddr] <= 1'b1;
						end
						if (clr_valid) begin
							valid_q[cmp_idx_q] <= 1'b0;
						end
					end else begin
						cmp_pend_q <= issue;
						cmp_idx_q  <= scan_q[IDX_W-1:0];
						if (issue) begin
							scan_q <= scan_q + CNT_W'(1);
						end
						if (cmp_pend_q && slot_free && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= cmp_idx_q;
						end
					end
				end
				WB: begin
					if (out_load) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_idx_q    <= res_idx_q;
						state_q      <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`CTE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
	`CTE_ASSERT_SAME(a_pend_in_scan, cmp_pend_q, state_q == SCAN, "compare pending outside scan")
	`CTE_ASSERT_SAME(a_added_valid, out_load && res_status_q == ST_ADDED, valid_q[res_idx_q], "added slot not valid")
	`CTE_ASSERT_SAME(a_deleted_free, out_load && res_status_q == ST_DELETED, !valid_q[res_idx_q], "deleted slot still valid")
	`CTE_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready, out_valid_q && $stable(out_status_q), "result dropped")

endmodule

[src/cte_ram.sv]
module cte_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
